// ===== hdl/ialu_pkg.sv =====
package ialu_pkg;

	// Field widths of the stream payload
	localparam int FIELD_W   = 16;
	localparam int OP_W      = 4;
	localparam int WIDTH_DEF = 16;

	// Bit positions of the result flags in m_tuser
	localparam int FLAG_CY = 0;
	localparam int FLAG_DZ = 1;

	// Operation codes carried in s_tuser
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_SHL = 4'd5,
		OP_SHR = 4'd6,
		OP_ROL = 4'd7,
		OP_ROR = 4'd8,
		OP_INV = 4'd9
	} op_t;

	// Control that travels with each request down the pipeline
	typedef struct packed {
		logic vld;     // stage holds a request
		logic div_op;  // divide or modulo: iterate the divider
		logic mod_sel; // deliver remainder instead of quotient
		logic cy;      // carry out of add or subtract
		logic dz;      // zero divisor
	} ctl_t;

endpackage

// ===== hdl/ialu_front.sv =====
module ialu_front #(
	parameter int DW = ialu_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [3:0]       in_op,
	input  logic [DW-1:0]    in_a,
	input  logic [DW-1:0]    in_b,
	input  logic             rdy_in,
	output logic             rdy_out,
	output ialu_pkg::ctl_t   ctl_s1,
	output logic [DW-1:0]    q_s1,
	output logic [DW-1:0]    dvs_s1
);

	ialu_pkg::op_t  op;
	ialu_pkg::ctl_t ctl_d;
	logic [DW-1:0]  neg_b;
	logic [DW-1:0]  addend;
	logic [DW:0]    sum;
	logic [DW-1:0]  prod;
	logic [DW-1:0]  res_d;

	assign op      = ialu_pkg::op_t'(in_op);
	assign rdy_out = !ctl_s1.vld || rdy_in;

	// Add and subtract share one adder; subtract adds the two's complement of b
	assign neg_b  = (~in_b) + {{(DW-1){1'b0}}, 1'b1};
	assign addend = (op == ialu_pkg::OP_SUB) ? neg_b : in_b;
	assign sum    = {1'b0, in_a} + {1'b0, addend};
	assign prod   = in_a * in_b;

	// Select the front-stage result and the control for the divider chain
	always_comb begin
		res_d       = '0;
		ctl_d       = '0;
		ctl_d.vld   = in_vld;
		case (op)
			ialu_pkg::OP_ADD,
			ialu_pkg::OP_SUB: begin
				res_d    = sum[DW-1:0];
				ctl_d.cy = sum[DW];
			end
			ialu_pkg::OP_MUL: res_d = prod;
			ialu_pkg::OP_DIV,
			ialu_pkg::OP_MOD: begin
				res_d         = in_a;
				ctl_d.div_op  = 1'b1;
				ctl_d.mod_sel = (op == ialu_pkg::OP_MOD);
				ctl_d.dz      = (in_b == '0);
			end
			ialu_pkg::OP_SHL: res_d = {in_a[DW-2:0], 1'b0};
			ialu_pkg::OP_SHR: res_d = {1'b0, in_a[DW-1:1]};
			ialu_pkg::OP_ROL: res_d = {in_a[DW-2:0], in_a[DW-1]};
			ialu_pkg::OP_ROR: res_d = {in_a[0], in_a[DW-1:1]};
			ialu_pkg::OP_INV: res_d = ~in_a;
			default:          res_d = '0;
		endcase
	end

	// Hold control under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_out) begin
			ctl_s1 <= ctl_d;
		end
	end

	// Capture payload when the stage advances
	always_ff @(posedge clk) begin
		if (rdy_out && in_vld) begin
			q_s1   <= res_d;
			dvs_s1 <= in_b;
		end
	end

	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld && ctl_s1.dz |-> ctl_s1.div_op)
		else $error("zero divisor flag on a non-divide request");

	a_cy_not_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld && ctl_s1.cy |-> !ctl_s1.div_op)
		else $error("carry set on a divide request");

endmodule

// ===== hdl/ialu_div_stage.sv =====
module ialu_div_stage #(
	parameter int DW = ialu_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ialu_pkg::ctl_t   ctl_in,
	input  logic [DW-1:0]    rem_in,
	input  logic [DW-1:0]    q_in,
	input  logic [DW-1:0]    dvs_in,
	input  logic             rdy_in,
	output logic             rdy_out,
	output ialu_pkg::ctl_t   ctl_sn,
	output logic [DW-1:0]    rem_sn,
	output logic [DW-1:0]    q_sn,
	output logic [DW-1:0]    dvs_sn
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;
	logic [DW-1:0] rem_d;
	logic [DW-1:0] q_d;

	assign rdy_out = !ctl_sn.vld || rdy_in;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_in, q_in[DW-1]};
	assign diff  = trial - {1'b0, dvs_in};
	assign fits  = (trial >= {1'b0, dvs_in});

	always_comb begin
		rem_d = rem_in;
		q_d   = q_in;
		if (ctl_in.div_op) begin
			rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
			q_d   = {q_in[DW-2:0], fits};
		end
	end

	// Hold control under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else if (rdy_out) begin
			ctl_sn <= ctl_in;
		end
	end

	// Advance payload with its request
	always_ff @(posedge clk) begin
		if (rdy_out && ctl_in.vld) begin
			rem_sn <= rem_d;
			q_sn   <= q_d;
			dvs_sn <= dvs_in;
		end
	end

endmodule

// ===== hdl/integer_alu.sv =====
// DW = min(WIDTH, 16) (16 at the default); requests pass the front stage, divider chain and output register.
// Throughput: one request per cycle unless m_tready stalls the output; the restoring divider
// is unrolled into one stage per quotient bit, with operand decode, adder and multiplier in the first stage.
// Each stage advances whenever the next one is empty or moving, so bubbles are squeezed out.
// Reset: arst_n asynchronously clears all valid bits; payload registers are not reset.
module integer_alu #(
	parameter int WIDTH = ialu_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] operand_a, [31:16] operand_b
	input  logic [3:0]  s_tuser,  // [3:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] result
	output logic [1:0]  m_tuser   // [0] carry_out, [1] div_by_zero
);

	localparam int DW = (WIDTH < ialu_pkg::FIELD_W) ? WIDTH : ialu_pkg::FIELD_W;

	ialu_pkg::ctl_t ctl_c [DW+1];
	logic [DW-1:0]  rem_c [DW+1];
	logic [DW-1:0]  q_c   [DW+1];
	logic [DW-1:0]  dvs_c [DW+1];
	logic           rdy_c [DW+2];

	logic                      out_vld_q;
	logic [ialu_pkg::FIELD_W-1:0] res_q;
	logic                      cy_q;
	logic                      dz_q;
	logic [ialu_pkg::FIELD_W-1:0] res_d;

	// Decode, add, multiply and shift
	ialu_front #(.DW(DW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s_tvalid),
		.in_op   (s_tuser),
		.in_a    (s_tdata[DW-1:0]),
		.in_b    (s_tdata[ialu_pkg::FIELD_W+DW-1:ialu_pkg::FIELD_W]),
		.rdy_in  (rdy_c[1]),
		.rdy_out (rdy_c[0]),
		.ctl_s1  (ctl_c[0]),
		.q_s1    (q_c[0]),
		.dvs_s1  (dvs_c[0])
	);

	assign rem_c[0] = '0;
	assign s_tready = rdy_c[0];

	// Divider chain, one quotient bit per stage
	for (genvar k = 1; k <= DW; k++) begin : g_div
		ialu_div_stage #(.DW(DW)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[k-1]),
			.rem_in  (rem_c[k-1]),
			.q_in    (q_c[k-1]),
			.dvs_in  (dvs_c[k-1]),
			.rdy_in  (rdy_c[k+1]),
			.rdy_out (rdy_c[k]),
			.ctl_sn  (ctl_c[k]),
			.rem_sn  (rem_c[k]),
			.q_sn    (q_c[k]),
			.dvs_sn  (dvs_c[k])
		);
	end

	// Pick quotient, remainder or pass-through result; force it to zero on a zero divisor
	assign rdy_c[DW+1] = !out_vld_q || m_tready;

	always_comb begin
		res_d         = '0;
		res_d[DW-1:0] = ctl_c[DW].mod_sel ? rem_c[DW] : q_c[DW];
		if (ctl_c[DW].dz) begin
			res_d = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rdy_c[DW+1]) begin
			out_vld_q <= ctl_c[DW].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[DW+1] && ctl_c[DW].vld) begin
			res_q <= res_d;
			cy_q  <= ctl_c[DW].cy;
			dz_q  <= ctl_c[DW].dz;
		end
	end

	assign m_tvalid                 = out_vld_q;
	assign m_tdata                  = res_q;
	assign m_tuser[ialu_pkg::FLAG_CY] = cy_q;
	assign m_tuser[ialu_pkg::FLAG_DZ] = dz_q;

	a_dz_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[ialu_pkg::FLAG_DZ] |-> (m_tdata == '0))
		else $error("zero divisor result is not zero");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[ialu_pkg::FLAG_CY] && m_tuser[ialu_pkg::FLAG_DZ]))
		else $error("carry and zero divisor flags both set");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output is free");

endmodule
